/* rtl/core/cda_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date advance package
// Shared constants, command codes and calendar helper functions.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam logic [15:0] MIN_YEAR  = 16'd1900;
  localparam logic [15:0] YEAR_MAX  = 16'd65535;

  // Divisibility by 25 of a 16-bit value: multiply by the inverse of 25
  // modulo 2^16 and compare against floor((2^16 - 1) / 25).
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_SET_DATE  = 3'd0;
  localparam cmd_t CMD_SET_MONTH = 3'd1;
  localparam cmd_t CMD_SET_DAY   = 3'd2;
  localparam cmd_t CMD_SET_YEAR  = 3'd3;
  localparam cmd_t CMD_ADVANCE   = 3'd4;

  function automatic logic is_leap(input logic [15:0] y);
    logic [31:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = {16'd0, y} * {16'd0, INV25};
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[15:0] <= DIV25_LIM);
    return div4 && (!div25 || div16);
  endfunction

  // Length of a month; zero for a month code outside 1 to 12.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of a month.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cda_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date advance channels
// Valid/ready channels for the command requests and the date results.
// ----------------------------------------------------------------------------
interface cda_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [15:0] new_year;
  logic [15:0] add_days;

  modport source (output valid, cmd, new_month, new_day, new_year, add_days,
                  input ready);
  modport sink   (input valid, cmd, new_month, new_day, new_year, add_days,
                  output ready);
endinterface

interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [15:0] year_out;
  logic [8:0]  days_passed;
  logic [8:0]  days_left;
  logic        leap;
  logic        error;

  modport source (output valid, month_out, day_out, year_out, days_passed,
                  days_left, leap, error, input ready);
  modport sink   (input valid, month_out, day_out, year_out, days_passed,
                  days_left, leap, error, output ready);
endinterface

`default_nettype wire

/* rtl/core/calendar_date_advance.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date advance
// Holds one Gregorian date and runs set and advance commands on it.
// ----------------------------------------------------------------------------
// Each request runs one command against the stored date and gives one result.
// A set command is checked in ST_CHECK and its result loaded from ST_FIN. An
// advance passes ST_CHECK, steps once in ST_YEAR for each year boundary crossed
// and once in ST_MONTH for each month stepped in the final year, then loads its
// result from ST_FIN. The length of an advance is set by the year and month walk, which
// runs through a single leap-year unit (one 16x16 multiply) and a single
// compare-and-subtract. The block takes no new request while a command runs;
// a finished result sits in the output register, so the next request can be
// taken while it waits.
module calendar_date_advance
  import cda_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  cda_in_if.sink     in_req,
  cda_out_if.source  out_res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_YEAR  = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  cur_month_r, cur_month_nxt;
  logic [4:0]  cur_day_r, cur_day_nxt;
  logic [15:0] cur_year_r, cur_year_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [3:0]  nm_r, nm_nxt;
  logic [4:0]  nd_r, nd_nxt;
  logic [15:0] na_r, na_nxt;
  logic [15:0] yr_r, yr_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [16:0] total_r, total_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [15:0] out_year_r;
  logic [8:0]  out_passed_r;
  logic [8:0]  out_left_r;
  logic        out_leap_r;
  logic        out_err_r;

  // Shared units: leap test of the working year, one month length lookup,
  // one compare-and-subtract on the running day count.
  logic        lp;
  logic [3:0]  md_month;
  logic [4:0]  md;
  logic [3:0]  chk_m;
  logic [4:0]  chk_d;
  logic        chk_ok;
  logic [8:0]  yd;
  logic [16:0] sub_amt;
  logic        sub_ge;
  logic [16:0] sub_diff;
  logic [8:0]  passed;
  logic [8:0]  left;
  logic        fin_load;

  assign lp = is_leap(yr_r);

  always_comb begin
    chk_m = cur_month_r;
    chk_d = cur_day_r;
    if (cmd_r inside {CMD_SET_DATE, CMD_SET_MONTH}) begin
      chk_m = nm_r;
    end
    if (cmd_r inside {CMD_SET_DATE, CMD_SET_DAY}) begin
      chk_d = nd_r;
    end
  end

  assign md_month = (state_r == ST_MONTH) ? m_r : chk_m;
  assign md       = month_days(md_month, lp);
  assign chk_ok   = (chk_m inside {[4'd1:4'd12]}) && (yr_r >= MIN_YEAR) &&
                    (chk_d != 5'd0) && (chk_d <= md);

  assign yd       = lp ? 9'd366 : 9'd365;
  assign sub_amt  = (state_r == ST_YEAR) ? {8'd0, yd} : {12'd0, md};
  assign sub_ge   = (total_r >= sub_amt);
  assign sub_diff = total_r - sub_amt;

  // Position of the stored date within the year; yr_r holds the stored year
  // whenever these are used.
  assign passed = days_before(cur_month_r) + {4'd0, cur_day_r - 5'd1} +
                  {8'd0, (cur_month_r > 4'd2) && lp};
  assign left   = (lp ? 9'd365 : 9'd364) - passed;

  assign fin_load     = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    cur_year_nxt  = cur_year_r;
    cmd_nxt       = cmd_r;
    nm_nxt        = nm_r;
    nd_nxt        = nd_r;
    na_nxt        = na_r;
    yr_nxt        = yr_r;
    m_nxt         = m_r;
    total_nxt     = total_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          cmd_nxt   = in_req.cmd;
          nm_nxt    = in_req.new_month;
          nd_nxt    = in_req.new_day;
          na_nxt    = in_req.add_days;
          err_nxt   = 1'b0;
          yr_nxt    = (in_req.cmd inside {CMD_SET_DATE, CMD_SET_YEAR}) ?
                      in_req.new_year : cur_year_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_FIN;
        case (cmd_r)
          CMD_SET_DATE: begin
            if (chk_ok) begin
              cur_month_nxt = nm_r;
              cur_day_nxt   = nd_r;
              cur_year_nxt  = yr_r;
            end else begin
              cur_month_nxt = 4'd1;
              cur_day_nxt   = 5'd1;
              cur_year_nxt  = MIN_YEAR;
              yr_nxt        = MIN_YEAR;
              err_nxt       = 1'b1;
            end
          end
          CMD_SET_MONTH: begin
            if (chk_ok) begin
              cur_month_nxt = nm_r;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_SET_DAY: begin
            if (chk_ok) begin
              cur_day_nxt = nd_r;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_SET_YEAR: begin
            if (chk_ok) begin
              cur_year_nxt = yr_r;
            end else begin
              yr_nxt  = cur_year_r;
              err_nxt = 1'b1;
            end
          end
          CMD_ADVANCE: begin
            total_nxt = {8'd0, passed} + {1'b0, na_r};
            m_nxt     = 4'd1;
            state_nxt = ST_YEAR;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
      ST_YEAR: begin
        if (sub_ge) begin
          if (yr_r == YEAR_MAX) begin
            // Past the last year: keep the stored date and flag it.
            yr_nxt    = cur_year_r;
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            total_nxt = sub_diff;
            yr_nxt    = yr_r + 16'd1;
          end
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if ((m_r != 4'd12) && sub_ge) begin
          total_nxt = sub_diff;
          m_nxt     = m_r + 4'd1;
        end else begin
          cur_year_nxt  = yr_r;
          cur_month_nxt = m_r;
          cur_day_nxt   = total_r[4:0] + 5'd1;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_month_r <= 4'd1;
      cur_day_r   <= 5'd1;
      cur_year_r  <= MIN_YEAR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    nm_r    <= nm_nxt;
    nd_r    <= nd_nxt;
    na_r    <= na_nxt;
    yr_r    <= yr_nxt;
    m_r     <= m_nxt;
    total_r <= total_nxt;
    err_r   <= err_nxt;
    if ((state_r == ST_FIN) && fin_load) begin
      out_month_r  <= cur_month_r;
      out_day_r    <= cur_day_r;
      out_year_r   <= cur_year_r;
      out_passed_r <= passed;
      out_left_r   <= left;
      out_leap_r   <= lp;
      out_err_r    <= err_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.month_out   = out_month_r;
  assign out_res.day_out     = out_day_r;
  assign out_res.year_out    = out_year_r;
  assign out_res.days_passed = out_passed_r;
  assign out_res.days_left   = out_left_r;
  assign out_res.leap        = out_leap_r;
  assign out_res.error       = out_err_r;

`ifndef SYNTH
  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= 4'd1) && (cur_month_r <= 4'd12) && (cur_day_r != 5'd0) &&
    (cur_year_r >= MIN_YEAR))
    else $error("stored date left the valid range");

  a_fin_year: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (yr_r == cur_year_r))
    else $error("working year differs from stored year at result time");

  a_result_date: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && fin_load) |=>
      ((out_res.year_out == cur_year_r) && (out_res.month_out == cur_month_r) &&
       (out_res.day_out == cur_day_r)))
    else $error("result does not match the stored date");

  a_year_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |->
      ((out_res.days_passed + out_res.days_left) ==
       (out_res.leap ? 9'd365 : 9'd364)))
    else $error("days passed and days left do not add up to the year");
`endif

endmodule

`default_nettype wire
